// ===== src/pbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsc_pkg: shared types and constants of the covariance accumulator
// Register indexes, opcodes, sequencer states and arithmetic widths.
// ----------------------------------------------------------------------------
package pbsc_pkg;

    localparam int unsigned DATA_W  = 24;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned OUT_W   = 49;
    localparam int unsigned CNT_W   = 24;

    localparam logic [0:0] OP_ACCUM = 1'b0;
    localparam logic [0:0] OP_READ  = 1'b1;

    localparam logic [0:0] REG_CHANNELS = 1'b0;
    localparam logic [0:0] REG_BINS     = 1'b1;

    typedef enum logic [2:0] {
        t_ST_CLEAR,
        t_ST_IDLE,
        t_ST_RD,
        t_ST_ACC,
        t_ST_DIV,
        t_ST_OUT
    } t_state;

    // Start request to the serial divider.
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== src/per_bin_spatial_covariance_accumulator.sv =====
// ----------------------------------------------------------------------------
// per_bin_spatial_covariance_accumulator: per-bin complex covariance store
// Accumulates x*x^H per frequency bin and reads out frame-averaged entries.
// ----------------------------------------------------------------------------
// After reset the block makes one clearing pass over all (FFT_LENGTH/2+1) *
// MAX_CHANNELS^2 entries (4112 by default), zeroing its accumulator memory;
// during it busy is high and no word is taken. An accumulate word then
// steps through each matrix entry in turn (memory read, product, saturating
// add and write back); the next word can be taken once busy is low. A
// readout with a nonzero frame count handles each entry with one memory
// read, two back-to-back divisions in the bit-serial 64-bit divider (real
// part, then imaginary part) and one output step. With a zero frame count
// the divider is not used. Results appear on the output ports for one
// cycle each, marked by o_valid; the receiver cannot stall, so it must
// take every word as it comes. Words for bins out of range are dropped
// without effect. Entries are real and imaginary 64-bit saturating sums
// held in one memory of 128-bit rows, with a registered read.
// ----------------------------------------------------------------------------
module per_bin_spatial_covariance_accumulator
    import pbsc_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int FFT_LENGTH   = 512
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [8:0]               i_cfg_data,
    input  logic                     i_opcode,
    input  logic [8:0]               i_bin_index,
    input  logic signed [DATA_W-1:0] i_ch0_real,
    input  logic signed [DATA_W-1:0] i_ch0_imag,
    input  logic signed [DATA_W-1:0] i_ch1_real,
    input  logic signed [DATA_W-1:0] i_ch1_imag,
    input  logic signed [DATA_W-1:0] i_ch2_real,
    input  logic signed [DATA_W-1:0] i_ch2_imag,
    input  logic signed [DATA_W-1:0] i_ch3_real,
    input  logic signed [DATA_W-1:0] i_ch3_imag,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_entry_real,
    output logic signed [OUT_W-1:0]  o_entry_imag,
    output logic [1:0]               o_row_index,
    output logic [1:0]               o_col_index,
    output logic                     o_no_frames,
    output logic                     o_last_entry
);

    localparam int BIN_COUNT = FFT_LENGTH / 2 + 1;
    localparam int MAT      = MAX_CHANNELS * MAX_CHANNELS;
    localparam int DEPTH    = BIN_COUNT * MAT;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] SMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Accumulator memory: {real, imag} per entry.
    logic [2*ACC_W-1:0] r_mem [DEPTH];
    logic [2*ACC_W-1:0] r_rdata;
    logic               w_we;
    logic [AW-1:0]      w_addr;
    logic [2*ACC_W-1:0] w_wdata;

    t_state r_state, n_state;

    logic [2:0]  r_chan_cfg;
    logic [8:0]  r_bins_cfg;
    logic [CNT_W-1:0] r_frames;
    logic [AW-1:0] r_clr;
    logic          r_op;
    logic [8:0]    r_bin;
    logic signed [DATA_W-1:0] r_xr [MAX_CHANNELS];
    logic signed [DATA_W-1:0] r_xi [MAX_CHANNELS];
    logic [CW-1:0] r_row, r_col;
    logic          r_phase;   // ACC: 0 = products, 1 = write back
    logic          r_part;    // DIV: 0 = real, 1 = imag
    logic signed [2*DATA_W:0] r_pre, r_pim;
    logic signed [OUT_W-1:0] r_qre;

    logic [2:0]  w_n;
    logic        w_in_range;
    logic        w_last;
    logic [AW-1:0] w_idx;
    t_div_req    w_req;
    logic        w_div_done;
    logic signed [OUT_W-1:0] w_quot;
    logic signed [ACC_W-1:0] w_sum_re, w_sum_im;
    logic signed [2*DATA_W-1:0] w_rr, w_ii, w_ir, w_ri;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [2*DATA_W:0] b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? SMIN : SMAX;
        return s[ACC_W-1:0];
    endfunction

    assign w_n = (r_chan_cfg == 3'd0) ? 3'd1 :
                 (r_chan_cfg > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : r_chan_cfg;
    assign w_in_range = (i_bin_index < r_bins_cfg) && (i_bin_index < 9'(BIN_COUNT));
    assign w_last = (3'(r_col) == w_n - 3'd1);
    assign w_idx = AW'(r_bin * MAT + r_row * MAX_CHANNELS + r_col);
    assign busy = (r_state != t_ST_IDLE);

    // Full-precision products of the current entry.
    assign w_rr = r_xr[r_row] * r_xr[r_col];
    assign w_ii = r_xi[r_row] * r_xi[r_col];
    assign w_ir = r_xi[r_row] * r_xr[r_col];
    assign w_ri = r_xr[r_row] * r_xi[r_col];

    // Next state. With a zero frame count the divider is never started:
    // DIV first marks both parts finished and then moves on to OUT.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = t_ST_IDLE;
            t_ST_IDLE:  if (start && w_in_range) n_state = t_ST_RD;
            t_ST_RD:    n_state = r_op ? t_ST_DIV : t_ST_ACC;
            t_ST_ACC: begin
                if (r_phase) begin
                    if (w_last && (3'(r_row) == w_n - 3'd1)) n_state = t_ST_IDLE;
                    else n_state = t_ST_RD;
                end
            end
            t_ST_DIV: begin
                if ((w_div_done || r_frames == '0) && r_part) n_state = t_ST_OUT;
            end
            t_ST_OUT: begin
                if (w_last && (3'(r_row) == w_n - 3'd1)) n_state = t_ST_IDLE;
                else n_state = t_ST_RD;
            end
            default:    n_state = t_ST_IDLE;
        endcase
    end

    // Memory control and divider request.
    always_comb begin
        w_we    = 1'b0;
        w_addr  = w_idx;
        w_wdata = {w_sum_re, w_sum_im};
        w_req.start    = 1'b0;
        w_req.dividend = r_rdata[2*ACC_W-1:ACC_W];
        w_req.divisor  = r_frames;
        unique case (r_state)
            t_ST_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr;
                w_wdata = '0;
            end
            t_ST_ACC:   w_we = r_phase;
            t_ST_DIV: begin
                if (r_frames != '0 && ((r_part == 1'b0 && !r_phase) ||
                                        (w_div_done && !r_part))) begin
                    w_req.start = 1'b1;
                end
                if (r_part == 1'b0 && w_div_done)
                    w_req.dividend = r_rdata[ACC_W-1:0];
            end
            default: ;
        endcase
    end

    assign w_sum_re = sat_add(r_rdata[2*ACC_W-1:ACC_W], r_pre);
    assign w_sum_im = sat_add(r_rdata[ACC_W-1:0], r_pim);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    pbsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= t_ST_CLEAR;
            r_clr      <= '0;
            r_chan_cfg <= 3'd1;
            r_bins_cfg <= 9'd257;
            r_frames   <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_phase    <= 1'b0;
            r_part     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CHANNELS) r_chan_cfg <= i_cfg_data[2:0];
                else                             r_bins_cfg <= i_cfg_data;
            end
            unique case (r_state)
                t_ST_CLEAR: r_clr <= r_clr + 1'b1;
                t_ST_IDLE: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_phase <= 1'b0;
                    r_part  <= 1'b0;
                    if (start && w_in_range && i_opcode == OP_ACCUM &&
                        i_bin_index == 9'd0 && r_frames != {CNT_W{1'b1}})
                        r_frames <= r_frames + 1'b1;
                end
                t_ST_RD: begin
                    r_phase <= 1'b0;
                    r_part  <= 1'b0;
                end
                t_ST_ACC: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        if (w_last) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                t_ST_DIV: begin
                    r_phase <= 1'b1;
                    if (r_frames == '0) begin
                        r_qre  <= '0;
                        r_part <= 1'b1;
                    end else if (w_div_done) begin
                        if (!r_part) r_qre <= w_quot;
                        r_part <= 1'b1;
                    end
                end
                t_ST_OUT: begin
                    o_valid <= 1'b1;
                    if (w_last) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == t_ST_IDLE && start) begin
            r_op  <= i_opcode;
            r_bin <= i_bin_index;
            r_xr[0] <= i_ch0_real; r_xi[0] <= i_ch0_imag;
            if (MAX_CHANNELS > 1) begin r_xr[1 % MAX_CHANNELS] <= i_ch1_real;
                r_xi[1 % MAX_CHANNELS] <= i_ch1_imag; end
            if (MAX_CHANNELS > 2) begin r_xr[2 % MAX_CHANNELS] <= i_ch2_real;
                r_xi[2 % MAX_CHANNELS] <= i_ch2_imag; end
            if (MAX_CHANNELS > 3) begin r_xr[3 % MAX_CHANNELS] <= i_ch3_real;
                r_xi[3 % MAX_CHANNELS] <= i_ch3_imag; end
        end
        if (r_state == t_ST_RD) begin
            r_pre <= (2*DATA_W+1)'(w_rr) + (2*DATA_W+1)'(w_ii);
            r_pim <= (2*DATA_W+1)'(w_ir) - (2*DATA_W+1)'(w_ri);
        end
        if (r_state == t_ST_OUT || (r_state == t_ST_DIV && n_state == t_ST_OUT)) begin
            o_entry_real <= (r_frames == '0) ? '0 : r_qre;
            o_entry_imag <= (r_frames == '0) ? '0 : w_quot;
            o_row_index  <= 2'(r_row);
            o_col_index  <= 2'(r_col);
            o_no_frames  <= (r_frames == '0);
            o_last_entry <= w_last && (3'(r_row) == w_n - 3'd1);
        end
    end

endmodule

// ===== src/pbsc_div.sv =====
// ----------------------------------------------------------------------------
// pbsc_div: serial signed-by-unsigned divider with 49-bit saturation
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module pbsc_div
    import pbsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_quot
);

    logic [ACC_W-1:0] r_mag, n_mag;
    logic [CNT_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_den;
    logic             r_neg;
    logic [6:0]       r_cnt;
    logic             r_busy;
    logic [CNT_W:0]   w_trial;
    logic signed [OUT_W-1:0] w_sat;

    always_comb begin
        w_trial = {r_rem[CNT_W-1:0], r_mag[ACC_W-1]};
        n_mag   = {r_mag[ACC_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_mag[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(ACC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[ACC_W-1];
            r_mag <= i_req.dividend[ACC_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    // r_mag now holds the unsigned quotient.
    always_comb begin
        if (r_neg) begin
            if (r_mag > {{(ACC_W-OUT_W+1){1'b0}}, 1'b1, {(OUT_W-2){1'b0}}} << 1)
                w_sat = {1'b1, {(OUT_W-1){1'b0}}};
            else
                w_sat = OUT_W'(~r_mag + 1'b1);
        end else begin
            if (r_mag > {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}})
                w_sat = {1'b0, {(OUT_W-1){1'b1}}};
            else
                w_sat = OUT_W'(r_mag);
        end
    end
    assign o_quot = w_sat;

endmodule

// ===== dv/per_bin_spatial_covariance_accumulator_test.sv =====
// ----------------------------------------------------------------------------
// per_bin_spatial_covariance_accumulator_test: self-checking testbench
// Drives accumulate and readout words through the command port, with random
// gaps and several register settings, and checks each result word against
// its behavioral covariance predictor or against entries typed in by hand.
// ----------------------------------------------------------------------------
module per_bin_spatial_covariance_accumulator_test;
    import pbsc_pkg::*;

    localparam int NCH       = 4;
    localparam int NBIN      = 257;
    localparam int DEPTH     = NBIN * NCH * NCH;
    localparam int IDLE_WAIT = 100;
    localparam int WD_LIMIT  = 20000;
    localparam longint OUT_HI = 64'sd281474976710655;
    localparam longint OUT_LO = -64'sd281474976710656;

    // One expected result word.
    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic [1:0]              row;
        logic [1:0]              col;
        logic                    nof;
        logic                    last;
    } t_entry;

    // One row of the directed stimulus table. A row flagged empty carries
    // a readout whose result is known on sight: all zero, no frames yet.
    typedef struct {
        logic [0:0]              op;
        logic [8:0]              bin;
        logic signed [DATA_W-1:0] x[8];
        bit                      empty;
    } t_stim;

    localparam logic signed [DATA_W-1:0] PMAX = 24'sh7FFFFF;
    localparam logic signed [DATA_W-1:0] NMIN = -24'sh800000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_cfg_we = 1'b0;
    logic                      i_cfg_index = 1'b0;
    logic [8:0]                i_cfg_data = '0;
    logic                      i_opcode = 1'b0;
    logic [8:0]                i_bin_index = '0;
    logic signed [DATA_W-1:0]  x_in[8] = '{default: '0};
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_entry_real;
    logic signed [OUT_W-1:0]   o_entry_imag;
    logic [1:0]                o_row_index;
    logic [1:0]                o_col_index;
    logic                      o_no_frames;
    logic                      o_last_entry;

    // Shadow of the block state: accumulators, frame count and registers.
    longint acc_re[DEPTH];
    longint acc_im[DEPTH];
    int     frames;
    int     chan_reg;
    int     bin_reg;

    t_entry pending_entries[$];
    int     errors;
    int     quiet_cycles = 0;

    per_bin_spatial_covariance_accumulator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_opcode),
        .i_bin_index  (i_bin_index),
        .i_ch0_real   (x_in[0]),
        .i_ch0_imag   (x_in[1]),
        .i_ch1_real   (x_in[2]),
        .i_ch1_imag   (x_in[3]),
        .i_ch2_real   (x_in[4]),
        .i_ch2_imag   (x_in[5]),
        .i_ch3_real   (x_in[6]),
        .i_ch3_imag   (x_in[7]),
        .o_valid      (o_valid),
        .o_entry_real (o_entry_real),
        .o_entry_imag (o_entry_imag),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_no_frames  (o_no_frames),
        .o_last_entry (o_last_entry)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Channel register as the block reads it: zero means one, and anything
    // above the channel count is clamped to it.
    function automatic int active_chans();
        if (chan_reg == 0) return 1;
        if (chan_reg > NCH) return NCH;
        return chan_reg;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
        return s;
    endfunction

    // Frame average, truncated toward zero and clamped to the output range.
    function automatic logic signed [OUT_W-1:0] frame_mean(longint acc);
        longint q;
        q = acc / longint'(frames);
        if (q > OUT_HI) q = OUT_HI;
        if (q < OUT_LO) q = OUT_LO;
        return q[OUT_W-1:0];
    endfunction

    // Update the shadow store for one accepted word and queue the result
    // words that a readout will produce.
    function automatic void predict_covariance(logic [0:0] op, int bin,
                                               logic signed [DATA_W-1:0] x[8]);
        int     n;
        int     idx;
        longint ar, ai, br, bi;
        t_entry e;
        n = active_chans();
        if (bin >= bin_reg || bin >= NBIN) return;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                idx = bin * NCH * NCH + r * NCH + c;
                if (op == OP_ACCUM) begin
                    ar = x[2*r]; ai = x[2*r+1];
                    br = x[2*c]; bi = x[2*c+1];
                    acc_re[idx] = sat_sum(acc_re[idx], ar * br + ai * bi);
                    acc_im[idx] = sat_sum(acc_im[idx], ai * br - ar * bi);
                end else begin
                    e.nof  = (frames == 0);
                    e.re   = e.nof ? '0 : frame_mean(acc_re[idx]);
                    e.im   = e.nof ? '0 : frame_mean(acc_im[idx]);
                    e.row  = r[1:0];
                    e.col  = c[1:0];
                    e.last = (r == n - 1 && c == n - 1);
                    pending_entries.push_back(e);
                end
            end
        end
        if (op == OP_ACCUM && bin == 0 && frames < 24'hFFFFFF)
            frames++;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Results are sampled at the falling edge, away from any update, so
    // each one-cycle word is seen exactly once.
    always @(negedge i_clk) begin
        t_entry e;
        if (i_rst_n && o_valid) begin
            if (pending_entries.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                e = pending_entries.pop_front();
                if (o_entry_real !== e.re) report_mismatch("entry_real", o_entry_real, e.re);
                if (o_entry_imag !== e.im) report_mismatch("entry_imag", o_entry_imag, e.im);
                if (o_row_index !== e.row) report_mismatch("row_index", o_row_index, e.row);
                if (o_col_index !== e.col) report_mismatch("col_index", o_col_index, e.col);
                if (o_no_frames !== e.nof) report_mismatch("no_frames", o_no_frames, e.nof);
                if (o_last_entry !== e.last)
                    report_mismatch("last_entry", o_last_entry, e.last);
            end
        end
    end

    // Watchdog: a long run of cycles where no word moves either way.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register write; the write port is then left idle before the task returns.
    task automatic write_reg(logic [0:0] idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_CHANNELS) chan_reg = value & 7;
        else bin_reg = value & 9'h1FF;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(40, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(1, 4);
    endfunction

    // Present one word and hold it until the block takes it. Called and
    // returning right after a rising edge. Words whose results are typed
    // in by the caller skip the predictor.
    task automatic send_word(logic [0:0] op, logic [8:0] bin,
                             logic signed [DATA_W-1:0] x[8], int gap,
                             bit use_pred);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_opcode    <= op;
        i_bin_index <= bin;
        for (int k = 0; k < 8; k++) x_in[k] <= x[k];
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (use_pred) predict_covariance(op, bin, x);
    endtask

    // Let all queued results arrive and the block fall quiet, so that a
    // register write lands while it is idle.
    task automatic drain();
        start <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return PMAX;
            1: return NMIN;
            2: return DATA_W'($urandom_range(0, 255)) - 24'sd128;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    t_stim directed_rows[12];

    initial begin
        logic signed [DATA_W-1:0] x[8];
        logic [8:0] bin;
        logic [0:0] op;
        t_entry     e;
        int         n;
        int         phase_ch[5];
        int         phase_bins[5];

        errors       = 0;
        frames       = 0;
        chan_reg     = 1;
        bin_reg      = NBIN;
        for (int k = 0; k < DEPTH; k++) begin
            acc_re[k] = 0;
            acc_im[k] = 0;
        end

        // Directed rows: empty readouts, full-scale inputs of both signs,
        // large averages near the top of the output range, bins out of
        // range, and an all-zero observation.
        directed_rows[0]  = '{OP_READ,  9'd3,   '{default: '0}, 1'b1};
        directed_rows[1]  = '{OP_ACCUM, 9'd256, '{default: PMAX}, 1'b0};
        directed_rows[2]  = '{OP_ACCUM, 9'd1,   '{default: NMIN}, 1'b0};
        directed_rows[3]  = '{OP_ACCUM, 9'd1,   '{default: NMIN}, 1'b0};
        directed_rows[4]  = '{OP_ACCUM, 9'd1,   '{PMAX, NMIN, NMIN, PMAX, PMAX, PMAX,
                                                  NMIN, NMIN}, 1'b0};
        directed_rows[5]  = '{OP_READ,  9'd1,   '{default: '0}, 1'b1};
        directed_rows[6]  = '{OP_ACCUM, 9'd0,   '{24'sd1, -24'sd1, 24'sd2, 24'sd3,
                                                  -24'sd5, 24'sd7, 24'sd11, -24'sd13},
                                                 1'b0};
        directed_rows[7]  = '{OP_ACCUM, 9'd257, '{default: PMAX}, 1'b0};
        directed_rows[8]  = '{OP_READ,  9'd511, '{default: '0}, 1'b0};
        directed_rows[9]  = '{OP_ACCUM, 9'd0,   '{default: '0}, 1'b0};
        directed_rows[10] = '{OP_READ,  9'd1,   '{default: '0}, 1'b0};
        directed_rows[11] = '{OP_READ,  9'd256, '{default: '0}, 1'b0};

        // Register settings of the random phases, extremes included:
        // zero and oversized channel counts, a single bin, bins past the end.
        phase_ch   = '{0, 7, 2, 3, 4};
        phase_bins = '{1, 300, 9, 257, 257};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Readout straight after reset, at the reset channel count of one.
        e = '{re: '0, im: '0, row: 2'd0, col: 2'd0, nof: 1'b1, last: 1'b1};
        pending_entries.push_back(e);
        send_word(OP_READ, 9'd0, directed_rows[0].x, 0, 1'b0);
        drain();
        write_reg(REG_CHANNELS, 4);
        write_reg(REG_BINS, 257);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].empty && frames == 0) begin
                // Known on sight: every entry zero with the empty flag set.
                n = active_chans();
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++) begin
                        e = '{re: '0, im: '0, row: r[1:0], col: c[1:0], nof: 1'b1,
                              last: (r == n - 1 && c == n - 1)};
                        pending_entries.push_back(e);
                    end
                send_word(directed_rows[i].op, directed_rows[i].bin,
                          directed_rows[i].x, pick_gap(), 1'b0);
            end else begin
                send_word(directed_rows[i].op, directed_rows[i].bin,
                          directed_rows[i].x, pick_gap(), 1'b1);
            end
        end
        drain();

        // Random phases: frames of accumulates over a few low bins, each
        // frame opened on bin 0, readouts of random bins, and some noise
        // with bins anywhere in the field.
        foreach (phase_ch[p]) begin
            write_reg(REG_CHANNELS, phase_ch[p]);
            write_reg(REG_BINS, phase_bins[p]);
            for (int i = 0; i < 20; i++) begin
                case ($urandom_range(0, 9))
                    0: begin op = 1'($urandom); bin = 9'($urandom); end
                    1, 2: begin op = OP_READ; bin = 9'($urandom_range(0, 9)); end
                    3: begin op = OP_ACCUM; bin = 9'd0; end
                    default: begin op = OP_ACCUM; bin = 9'($urandom_range(0, 9)); end
                endcase
                for (int k = 0; k < 8; k++) x[k] = rand_sample();
                send_word(op, bin, x, pick_gap(), 1'b1);
            end
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
